FILE: hw/rtl/ship_rrip_stream_replacement_unit_assert.svh
// Assertion macros used by the replacement unit back end RTL.
`ifndef SHIP_RRIP_STREAM_REPLACEMENT_UNIT_ASSERT_SVH
`define SHIP_RRIP_STREAM_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication
`define SRRIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRRIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/srrip_pkg.sv
// Shared types and constants of the RRIP replacement unit.
`default_nettype none
package srrip_pkg;

  localparam logic [1:0] RRPV_TOP = 2'd3;
  localparam logic [1:0] NEAR_INS = 2'd0;
  localparam logic [1:0] FAR_INS  = 2'd2;
  localparam logic [1:0] CNT_TOP  = 2'd3;
  localparam logic [1:0] CNT_INIT = 2'd1;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic REG_REUSE_THR  = 1'b0;
  localparam logic REG_STREAM_TOL = 1'b1;

  localparam int unsigned LEAD_A_MUL = 37;
  localparam int unsigned LEAD_B_MUL = 71;
  localparam int unsigned LEAD_B_OFF = 13;

  typedef enum logic [1:0] {
    KIND_FOLLOW = 2'd0,
    KIND_SHIP   = 2'd1,
    KIND_BRRIP  = 2'd2
  } leader_kind_t;

  typedef struct packed {
    logic [1:0] reuse_threshold;
    logic [1:0] stream_tolerance;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ship_rrip_stream_replacement_unit.sv
// Top level of the RRIP/SHiP stream replacement unit.
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid/in_tready    | tdata: set, way, pc, addr; tuser: op, hit
//  out_    | out | out_tvalid/out_tready  | tdata: victim_way, inserted_rrpv, streaming_seen
//  cfg_    | in  | APB psel/penable       | reuse_threshold @0, stream_tolerance @4
// Each item passes through the back end in order: set-row read, compute, write-back.
// Items follow one another: the back end takes no new item until the last is written
// back; a two-beat queue lets the input side run ahead of a stalled output.
// After reset a clearing pass writes SETS rows, one per cycle, with in_tready low;
// config writes are taken throughout.
`default_nettype none
module ship_rrip_stream_replacement_unit #(
  parameter int SETS          = 2048,
  parameter int WAYS          = 16,
  parameter int HISTORY_LEN   = 4,
  parameter int LEAD_SET_CNT  = 32,
  parameter int SIG_BITS      = 6,
  parameter int SELECTOR_BITS = 10
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [10:0] set_index, [14:11] way, [78:15] pc, [142:79] phys_addr
  input  wire logic [143:0] in_tdata,
  // [0] operation, [1] hit
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [3:0] victim_way, [5:4] inserted_rrpv, [6] streaming_seen
  output logic [7:0]        out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import srrip_pkg::*;

  localparam int ENT_W = 1 + 1 + 2 + $clog2(SETS) + $clog2(WAYS) + SIG_BITS + 64;

  cfg_t             cfg_r;
  back_status_t     status;
  logic             q_full, q_valid, push, pop;
  logic [ENT_W-1:0] push_data, pop_data;
  logic             wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reuse_threshold  <= 2'd1;
      cfg_r.stream_tolerance <= 2'd2;
    end else if (wr) begin
      case (cfg_paddr[2])
        REG_REUSE_THR:  cfg_r.reuse_threshold  <= cfg_pwdata[1:0];
        REG_STREAM_TOL: cfg_r.stream_tolerance <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_REUSE_THR:  cfg_prdata = {30'd0, cfg_r.reuse_threshold};
      REG_STREAM_TOL: cfg_prdata = {30'd0, cfg_r.stream_tolerance};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  srrip_front #(
    .SETS(SETS), .WAYS(WAYS), .LEAD_SET_CNT(LEAD_SET_CNT), .SIG_BITS(SIG_BITS), .ENT_W(ENT_W)
  ) u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .q_full(q_full), .status(status), .push(push), .push_data(push_data)
  );

  srrip_fifo #(.W(ENT_W)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .pop_data(pop_data), .not_empty(q_valid)
  );

  srrip_back #(
    .SETS(SETS), .WAYS(WAYS), .HISTORY_LEN(HISTORY_LEN), .SIG_BITS(SIG_BITS),
    .SELECTOR_BITS(SELECTOR_BITS), .ENT_W(ENT_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_data(pop_data), .q_pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata), .status(status)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/srrip_front.sv
// Front end: beat acceptance, set/way reduction, signature and leader classification.
`default_nettype none
module srrip_front #(
  parameter int SETS         = 2048,
  parameter int WAYS         = 16,
  parameter int LEAD_SET_CNT = 32,
  parameter int SIG_BITS     = 6,
  parameter int ENT_W        = 100
) (
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [1:0]               in_tuser,
  input  wire logic [143:0]             in_tdata,
  input  wire logic                     q_full,
  input  wire srrip_pkg::back_status_t  status,
  output logic                          push,
  output logic [ENT_W-1:0]              push_data
);
  import srrip_pkg::*;

  localparam int SET_BITS = $clog2(SETS);
  localparam int WAY_BITS = $clog2(WAYS);

  typedef struct packed {
    logic                op;
    logic                hit;
    leader_kind_t        kind;
    logic [SET_BITS-1:0] set;
    logic [WAY_BITS-1:0] way;
    logic [SIG_BITS-1:0] sig;
    logic [63:0]         addr;
  } ent_t;

  logic [SET_BITS-1:0]     set_s;
  logic [LEAD_SET_CNT-1:0] hit_a;
  logic [LEAD_SET_CNT-1:0] hit_b;
  leader_kind_t            kind;
  ent_t                    ent;

  assign set_s = SET_BITS'(in_tdata[10:0]);

  for (genvar i = 0; i < LEAD_SET_CNT; i++) begin : g_lead
    localparam int unsigned LA = (i * LEAD_A_MUL) % SETS;
    localparam int unsigned LB = (i * LEAD_B_MUL + LEAD_B_OFF) % SETS;
    assign hit_a[i] = (set_s == SET_BITS'(LA));
    assign hit_b[i] = (set_s == SET_BITS'(LB));
  end

  always_comb begin
    kind = KIND_FOLLOW;
    for (int i = 0; i < LEAD_SET_CNT; i++) begin
      if (kind == KIND_FOLLOW && hit_a[i]) kind = KIND_SHIP;
      if (kind == KIND_FOLLOW && hit_b[i]) kind = KIND_BRRIP;
    end
  end

  always_comb begin
    ent.op   = in_tuser[0];
    ent.hit  = in_tuser[1];
    ent.kind = kind;
    ent.set  = set_s;
    ent.way  = WAY_BITS'(in_tdata[14:11]);
    ent.sig  = in_tdata[15+2+:SIG_BITS] ^ SIG_BITS'(set_s);
    ent.addr = in_tdata[142:79];
  end

  assign in_tready = !q_full && !status.clearing;
  assign push      = in_tvalid && in_tready;
  assign push_data = ent;

endmodule
`default_nettype wire

FILE: hw/rtl/srrip_fifo.sv
// Two-entry queue between front and back.
`default_nettype none
module srrip_fifo #(
  parameter int W = 100
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              not_empty
);
  logic [W-1:0] buf_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= push_data;
  end

  assign pop_data  = buf_r[rp_r];
  assign full      = cnt_r[1];
  assign not_empty = (cnt_r != 2'd0);

endmodule
`default_nettype wire

FILE: hw/rtl/srrip_back.sv
// Back end: set-row memories, clearing pass, RRIP/SHiP/duel execution, result register.
`default_nettype none
module srrip_back #(
  parameter int SETS          = 2048,
  parameter int WAYS          = 16,
  parameter int HISTORY_LEN   = 4,
  parameter int SIG_BITS      = 6,
  parameter int SELECTOR_BITS = 10,
  parameter int ENT_W         = 100
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire srrip_pkg::cfg_t          cfg,
  input  wire logic                     q_valid,
  input  wire logic [ENT_W-1:0]         q_data,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [7:0]                    out_tdata,
  output srrip_pkg::back_status_t       status
);
  import srrip_pkg::*;
  `include "ship_rrip_stream_replacement_unit_assert.svh"

  localparam int SET_BITS = $clog2(SETS);
  localparam int WAY_BITS = $clog2(WAYS);
  localparam int CNT_N    = 1 << SIG_BITS;
  localparam int PTR_W    = $clog2(HISTORY_LEN);
  localparam int MISS_W   = $clog2(HISTORY_LEN);
  localparam int SEL_TOP  = (1 << SELECTOR_BITS) - 1;
  localparam int SEL_MID  = SEL_TOP / 2;

  typedef struct packed {
    logic                op;
    logic                hit;
    leader_kind_t        kind;
    logic [SET_BITS-1:0] set;
    logic [WAY_BITS-1:0] way;
    logic [SIG_BITS-1:0] sig;
    logic [63:0]         addr;
  } ent_t;

  typedef struct packed {
    logic                valid;
    logic [SIG_BITS-1:0] sig;
    logic [1:0]          rrpv;
  } line_t;

  typedef line_t [WAYS-1:0] meta_row_t;
  typedef logic [CNT_N-1:0][1:0] cnt_row_t;

  typedef struct packed {
    logic                          started;
    logic [PTR_W-1:0]              ptr;
    logic [HISTORY_LEN-1:0][15:0]  ring;
    logic [63:0]                   last;
  } det_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EX1   = 2'd2,
    ST_EX2   = 2'd3
  } state_t;

  meta_row_t meta_mem [SETS];
  cnt_row_t  cnt_mem  [SETS];
  det_t      det_mem  [SETS];

  ent_t                q_ent;
  meta_row_t           meta_q;
  cnt_row_t            cnt_q;
  det_t                det_q;

  state_t              state_r;
  logic [SET_BITS-1:0] clr_r;
  ent_t                ent_r;
  meta_row_t           meta_row_r, meta_row_nxt;
  cnt_row_t            cnt_row_r, cnt_row_nxt;
  det_t                det_r, det_nxt;
  logic [WAY_BITS-1:0] victim_r, victim_nxt;
  logic [SELECTOR_BITS-1:0] psel_r, psel_nxt;
  logic                out_valid_r;
  logic [7:0]          out_data_r, out_data_nxt;

  logic                mem_we;
  logic [SET_BITS-1:0] mem_wa;
  meta_row_t           meta_wd;
  cnt_row_t            cnt_wd;
  det_t                det_wd;
  logic                fire;

  line_t               cur_ln;
  logic                has3, has2, has1;
  logic [1:0]          top, age;
  logic [MISS_W-1:0]   miss;
  logic                strm, reuse, far;
  logic [1:0]          ins;
  line_t               new_ln;

  assign q_ent = ent_t'(q_data);

  // set-row memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      meta_mem[mem_wa] <= meta_wd;
      cnt_mem[mem_wa]  <= cnt_wd;
      det_mem[mem_wa]  <= det_wd;
    end
    meta_q <= meta_mem[q_ent.set];
    cnt_q  <= cnt_mem[q_ent.set];
    det_q  <= det_mem[q_ent.set];
  end

  // EX1: aging / victim pick, detector ring, counter adjust
  always_comb begin
    cur_ln = meta_q[ent_r.way];
    has3 = 1'b0;
    has2 = 1'b0;
    has1 = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      has3 = has3 | (meta_q[i].rrpv == 2'd3);
      has2 = has2 | (meta_q[i].rrpv == 2'd2);
      has1 = has1 | (meta_q[i].rrpv == 2'd1);
    end
    top = has3 ? 2'd3 : has2 ? 2'd2 : has1 ? 2'd1 : 2'd0;
    age = RRPV_TOP - top;
    victim_nxt = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (meta_q[i].rrpv == top) victim_nxt = WAY_BITS'(i);
    end
    meta_row_nxt = meta_q;
    if (ent_r.op == OP_VICTIM) begin
      for (int i = 0; i < WAYS; i++) meta_row_nxt[i].rrpv = meta_q[i].rrpv + age;
    end

    det_nxt = det_q;
    cnt_row_nxt = cnt_q;
    if (ent_r.op == OP_UPDATE) begin
      if (!det_q.started) begin
        det_nxt.started = 1'b1;
        det_nxt.ptr     = '0;
        det_nxt.ring    = '0;
      end else begin
        det_nxt.ring[det_q.ptr] = ent_r.addr[15:0] - det_q.last[15:0];
        det_nxt.ptr = (det_q.ptr == PTR_W'(HISTORY_LEN - 1)) ? '0 : det_q.ptr + 1'b1;
      end
      det_nxt.last = ent_r.addr;
      if (ent_r.hit) begin
        if (cnt_q[ent_r.sig] != CNT_TOP) cnt_row_nxt[ent_r.sig] = cnt_q[ent_r.sig] + 2'd1;
      end else if (cur_ln.valid && cnt_q[cur_ln.sig] != 2'd0) begin
        cnt_row_nxt[cur_ln.sig] = cnt_q[cur_ln.sig] - 2'd1;
      end
    end
  end

  // EX2: stream verdict, insertion choice, selector
  always_comb begin
    miss = '0;
    for (int i = 1; i < HISTORY_LEN; i++) begin
      miss = miss + MISS_W'(det_r.ring[i] != det_r.ring[0]);
    end
    strm  = ((MISS_W + 2)'(miss) <= (MISS_W + 2)'(cfg.stream_tolerance)) &&
            (det_r.ring[0] != 16'd0);
    reuse = cnt_row_r[ent_r.sig] >= cfg.reuse_threshold;
    far   = (ent_r.kind == KIND_BRRIP) ||
            (ent_r.kind == KIND_FOLLOW && psel_r < SELECTOR_BITS'(SEL_MID));
    if (ent_r.hit) ins = NEAR_INS;
    else if (far || strm || !reuse) ins = FAR_INS;
    else ins = NEAR_INS;

    new_ln.valid = 1'b1;
    new_ln.sig   = ent_r.sig;
    new_ln.rrpv  = ins;

    psel_nxt = psel_r;
    if (ent_r.op == OP_UPDATE && !ent_r.hit) begin
      if (ent_r.kind == KIND_SHIP && psel_r != SELECTOR_BITS'(SEL_TOP)) psel_nxt = psel_r + 1'b1;
      else if (ent_r.kind == KIND_BRRIP && psel_r != '0) psel_nxt = psel_r - 1'b1;
    end

    if (ent_r.op == OP_VICTIM) out_data_nxt = {4'd0, 4'(victim_r)};
    else out_data_nxt = {1'b0, strm, ins, 4'd0};
  end

  assign fire  = (state_r == ST_EX2) && (!out_valid_r || out_tready);
  assign q_pop = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    mem_we  = (state_r == ST_CLEAR) || fire;
    mem_wa  = (state_r == ST_CLEAR) ? clr_r : ent_r.set;
    meta_wd = meta_row_r;
    cnt_wd  = cnt_row_r;
    det_wd  = det_r;
    if (state_r == ST_CLEAR) begin
      for (int i = 0; i < WAYS; i++) begin
        meta_wd[i].valid = 1'b0;
        meta_wd[i].sig   = '0;
        meta_wd[i].rrpv  = RRPV_TOP;
      end
      for (int i = 0; i < CNT_N; i++) cnt_wd[i] = CNT_INIT;
      det_wd = '0;
    end else if (ent_r.op == OP_UPDATE) begin
      meta_wd[ent_r.way] = new_ln;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      psel_r      <= SELECTOR_BITS'(SEL_MID);
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SET_BITS'(SETS - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            ent_r   <= q_ent;
            state_r <= ST_EX1;
          end
        end
        ST_EX1: begin
          meta_row_r <= meta_row_nxt;
          cnt_row_r  <= cnt_row_nxt;
          det_r      <= det_nxt;
          victim_r   <= victim_nxt;
          state_r    <= ST_EX2;
        end
        ST_EX2: begin
          if (fire) begin
            psel_r     <= psel_nxt;
            out_data_r <= out_data_nxt;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      out_valid_r <= fire || (out_valid_r && !out_tready);
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign status.clearing = (state_r == ST_CLEAR);

  `SRRIP_ASSERT_NOW(a_no_pop_clear, state_r == ST_CLEAR, !q_pop, "pop during clearing pass")
  `SRRIP_ASSERT_NEXT(a_ex2_done, state_r == ST_EX2 && !out_valid_r, state_r == ST_IDLE && out_valid_r, "free result register not loaded")
  `SRRIP_ASSERT_NEXT(a_victim_fields, fire && ent_r.op == OP_VICTIM, out_data_r[7:4] == 4'd0, "victim beat carries update fields")
  `SRRIP_ASSERT_NOW(a_hold_unpopped, state_r != ST_IDLE, !q_pop, "queue popped while busy")

endmodule
`default_nettype wire
